/* rtl/ptt_pkg.sv */
// Shared types, constants and helpers for the pan/tilt target tracker.
// Used by ptt_div, ptt_core and pan_tilt_target_tracker; no dependencies.
package ptt_pkg;

  localparam logic [7:0] PAN_MIN          = 8'd0;
  localparam logic [7:0] PAN_MAX          = 8'd255;
  localparam logic [7:0] TILT_MIN         = 8'd0;
  localparam logic [7:0] TILT_MAX         = 8'd255;
  localparam logic [7:0] PAN_SEARCH_STEP  = 8'd50;
  localparam logic [7:0] TILT_SEARCH_STEP = 8'd50;

  localparam logic [7:0] PAN_MID  = 8'((int'(PAN_MIN) + int'(PAN_MAX)) / 2);
  localparam logic [7:0] TILT_MID = 8'((int'(TILT_MIN) + int'(TILT_MAX)) / 2);

  typedef enum logic [2:0] {
    REG_CONF_THR   = 3'd0,
    REG_PAN_TARGET = 3'd1,
    REG_TILT_TARGET = 3'd2,
    REG_PAN_BAND   = 3'd3,
    REG_TILT_BAND  = 3'd4,
    REG_PAN_GAIN   = 3'd5,
    REG_TILT_GAIN  = 3'd6,
    REG_SEARCH_DLY = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_VIEW   = 2'd1,
    ST_ON     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] conf_thr;
    logic [7:0] pan_target;
    logic [7:0] tilt_target;
    logic [7:0] pan_band;
    logic [7:0] tilt_band;
    logic [7:0] pan_gain;
    logic [7:0] tilt_gain;
    logic [7:0] search_dly;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] pan;
    logic [7:0] tilt;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic       neg;
    logic [7:0] mag;
  } err_t;

  // Split pixel - target into sign and magnitude.
  function automatic err_t err_split(input logic [7:0] pixel, input logic [7:0] target);
    logic [8:0] diff;
    logic [8:0] negd;
    err_t       e;
    diff  = {1'b0, pixel} - {1'b0, target};
    negd  = 9'd0 - diff;
    e.neg = diff[8];
    e.mag = diff[8] ? negd[7:0] : diff[7:0];
    return e;
  endfunction

  // Apply a signed step of at least 1 (when moving) and clamp to [lo, hi].
  function automatic logic [7:0] axis_move(input logic [7:0] pos, input logic [7:0] quo,
                                           input logic moving, input logic neg,
                                           input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0]        step;
    logic signed [9:0] sum;
    logic [7:0]        res;
    step = (quo == 8'd0) ? 8'd1 : quo;
    if (!moving) step = 8'd0;
    sum = neg ? ($signed({2'b00, pos}) - $signed({2'b00, step}))
              : ($signed({2'b00, pos}) + $signed({2'b00, step}));
    if (sum < $signed({2'b00, lo}))      res = lo;
    else if (sum > $signed({2'b00, hi})) res = hi;
    else                                 res = sum[7:0];
    return res;
  endfunction

endpackage

/* rtl/ptt_div.sv */
// Serial restoring divider, 8-bit by 8-bit, one quotient bit per cycle.
// Depends on ptt_pkg for the request and response structs.
module ptt_div import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic       busy;
  logic       done;
  logic [2:0] count;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] dvs;
  logic [8:0] shifted;
  logic [9:0] diff;
  logic       fit;
  logic [7:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[7]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    fit      = !diff[9];
    rem_next = fit ? diff[7:0] : shifted[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 3'd0;
      end else if (busy) begin
        count <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= 8'd0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[6:0], fit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/ptt_core.sv */
// Tracker sequencer: search pattern, per-axis error handling and servo state.
// Shares one ptt_div between the pan and tilt axes; depends on ptt_pkg.
module ptt_core import ptt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] packet_confidence,
  input  logic [7:0] centroid_x,
  input  logic [7:0] centroid_y,
  output logic       idle,
  input  logic       res_free,
  output result_t    res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAN  = 4'b0010,
    S_TILT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t     state;
  logic [7:0] pan_now;
  logic [7:0] tilt_now;
  logic       fresh_search;
  logic [7:0] search_wait;
  status_t    status;
  logic [7:0] cy_hold;
  logic       axis_neg;
  logic       axis_mv;
  logic       pan_settled;

  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic       in_accept;
  logic       tracked;
  err_t       pan_err;
  err_t       tilt_err;
  logic       pan_mv;
  logic       tilt_mv;
  logic [7:0] pan_div;
  logic [7:0] tilt_div;

  logic [7:0] wait_inc;
  logic       search_move;
  logic [7:0] search_wait_next;
  logic [7:0] pan_search;
  logic [7:0] tilt_search;
  logic [8:0] pan_sum;
  logic [8:0] tilt_sum;

  ptt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    in_accept = in_valid && (state == S_IDLE);
    tracked   = packet_confidence >= cfg.conf_thr;
    pan_err   = err_split(centroid_x, cfg.pan_target);
    tilt_err  = err_split(cy_hold, cfg.tilt_target);
    pan_mv    = pan_err.mag > cfg.pan_band;
    tilt_mv   = tilt_err.mag > cfg.tilt_band;
    pan_div   = (cfg.pan_gain == 8'd0) ? 8'd1 : cfg.pan_gain;
    tilt_div  = (cfg.tilt_gain == 8'd0) ? 8'd1 : cfg.tilt_gain;

    div_req.start    = (in_accept && tracked) || ((state == S_PAN) && div_rsp.done);
    div_req.dividend = (state == S_IDLE) ? pan_err.mag : tilt_err.mag;
    div_req.divisor  = (state == S_IDLE) ? pan_div : tilt_div;
  end

  // Raster search step on a low-confidence word.
  always_comb begin
    wait_inc         = search_wait + 8'd1;
    search_move      = wait_inc > cfg.search_dly;
    search_wait_next = search_move ? 8'd0 : wait_inc;
    pan_sum          = {1'b0, pan_now} + {1'b0, PAN_SEARCH_STEP};
    tilt_sum         = {1'b0, tilt_now} + {1'b0, TILT_SEARCH_STEP};
    pan_search       = pan_now;
    tilt_search      = tilt_now;
    if (search_move) begin
      if (fresh_search) begin
        pan_search  = PAN_MIN;
        tilt_search = TILT_MID;
      end else if (pan_now >= PAN_MAX) begin
        pan_search = PAN_MIN;
        if (tilt_now >= TILT_MAX)            tilt_search = TILT_MIN;
        else if (tilt_sum >= {1'b0, TILT_MAX}) tilt_search = TILT_MAX;
        else                                  tilt_search = tilt_sum[7:0];
      end else begin
        if (pan_sum >= {1'b0, PAN_MAX}) pan_search = PAN_MAX;
        else                            pan_search = pan_sum[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pan_now      <= PAN_MID;
      tilt_now     <= TILT_MID;
      fresh_search <= 1'b1;
      search_wait  <= 8'd0;
      status       <= ST_SEARCH;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (tracked) begin
              fresh_search <= 1'b1;
              state        <= S_PAN;
            end else begin
              search_wait <= search_wait_next;
              if (search_move) fresh_search <= 1'b0;
              pan_now  <= pan_search;
              tilt_now <= tilt_search;
              status   <= ST_SEARCH;
              state    <= S_OUT;
            end
          end
        end
        S_PAN: begin
          if (div_rsp.done) begin
            pan_now <= axis_move(pan_now, div_rsp.quotient, axis_mv, axis_neg,
                                 PAN_MIN, PAN_MAX);
            state   <= S_TILT;
          end
        end
        S_TILT: begin
          if (div_rsp.done) begin
            tilt_now <= axis_move(tilt_now, div_rsp.quotient, axis_mv, axis_neg,
                                  TILT_MIN, TILT_MAX);
            status   <= (pan_settled && !axis_mv) ? ST_ON : ST_VIEW;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-axis sign and move flag for the division in flight.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cy_hold  <= centroid_y;
      axis_neg <= pan_err.neg;
      axis_mv  <= pan_mv;
    end else if ((state == S_PAN) && div_rsp.done) begin
      pan_settled <= !axis_mv;
      axis_neg    <= tilt_err.neg;
      axis_mv     <= tilt_mv;
    end
  end

  assign idle       = (state == S_IDLE);
  assign res.valid  = (state == S_OUT);
  assign res.pan    = pan_now;
  assign res.tilt   = tilt_now;
  assign res.status = status;

endmodule

/* rtl/pan_tilt_target_tracker.sv */
// Pan/tilt target tracker top level: configuration registers and output register.
// Instantiates ptt_core (which holds ptt_div); depends on ptt_pkg.
//
// Usage: the input channel (in_valid/in_stall) carries one camera word:
// packet_confidence, centroid_x, centroid_y. Each word yields one output word
// (pan_position, tilt_position, track_status) on out_valid/out_stall.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. A tracked word
// (confidence at or above threshold) runs a serial division for pan, then one
// for tilt, on the shared divider; a search word (low confidence) runs none.
// The next word is taken only once the result of the last has moved on to the
// output register.
// in_stall is high while a word is in progress. The finished result sits in the
// output register; the next word is taken while it waits, and its result waits
// in the sequencer until out_stall lets the output register drain.
// Reset (rst, synchronous) restores register defaults, centres both servos,
// arms a fresh search and empties the output register.
module pan_tilt_target_tracker import ptt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] packet_confidence,
  input  logic [7:0] centroid_x,
  input  logic [7:0] centroid_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pan_position,
  output logic [7:0] tilt_position,
  output logic [1:0] track_status,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    idle;
  logic    res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_thr    <= 8'd25;
      cfg.pan_target  <= 8'd79;
      cfg.tilt_target <= 8'd119;
      cfg.pan_band    <= 8'd6;
      cfg.tilt_band   <= 8'd6;
      cfg.pan_gain    <= 8'd10;
      cfg.tilt_gain   <= 8'd10;
      cfg.search_dly  <= 8'd7;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CONF_THR:    cfg.conf_thr    <= cfg_data;
        REG_PAN_TARGET:  cfg.pan_target  <= cfg_data;
        REG_TILT_TARGET: cfg.tilt_target <= cfg_data;
        REG_PAN_BAND:    cfg.pan_band    <= cfg_data;
        REG_TILT_BAND:   cfg.tilt_band   <= cfg_data;
        REG_PAN_GAIN:    cfg.pan_gain    <= cfg_data;
        REG_TILT_GAIN:   cfg.tilt_gain   <= cfg_data;
        REG_SEARCH_DLY:  cfg.search_dly  <= cfg_data;
        default: ;
      endcase
    end
  end

  ptt_core u_core (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .packet_confidence (packet_confidence),
    .centroid_x        (centroid_x),
    .centroid_y        (centroid_y),
    .idle              (idle),
    .res_free          (res_free),
    .res               (res)
  );

  assign in_stall = !idle;
  assign res_free = !out_valid || !out_stall;

  // Load the output register when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      pan_position  <= res.pan;
      tilt_position <= res.tilt;
      track_status  <= res.status;
    end
  end

endmodule
